FILE: src/stfs_pkg.sv
// Shared types and constants for the sorted-table floor search block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package stfs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int KEY_W       = 32;

    // Item commands.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHK_LO = 5'b00010,
        ST_CHK_HI = 5'b00100,
        ST_SRCH   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic start;
        logic chk_lo;
        logic chk_hi;
        logic srch;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: src/stfs_ctrl.sv
// Controller state machine of the floor search block.
// Depends on stfs_pkg for the state encoding and the command and status structs.
`timescale 1ns / 1ps

module stfs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               cmd,
    output logic               in_stall,
    input  stfs_pkg::dp_stat_t stat,
    output stfs_pkg::ctrl_cmd_t ctl
);
    import stfs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   idle;

    assign idle     = (state_reg == ST_IDLE);
    assign in_stall = !idle;

    always_comb
    begin
        ctl        = '0;
        ctl.wr_en  = idle && in_valid && (cmd == CMD_WRITE);
        ctl.start  = idle && in_valid && (cmd == CMD_LOOKUP);
        ctl.chk_lo = (state_reg == ST_CHK_LO);
        ctl.chk_hi = (state_reg == ST_CHK_HI);
        ctl.srch   = (state_reg == ST_SRCH);
        ctl.emit   = (state_reg == ST_EMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = ST_CHK_LO;
                end
            end
            ST_CHK_LO:
            begin
                state_next = ST_CHK_HI;
            end
            ST_CHK_HI, ST_SRCH:
            begin
                state_next = stat.done ? ST_EMIT : ST_SRCH;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/stfs_dpath.sv
// Datapath of the floor search block: key table memory, search bounds,
// count register and output register. Depends on stfs_pkg.
`timescale 1ns / 1ps

module stfs_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stfs_pkg::ctrl_cmd_t                   ctl,
    output stfs_pkg::dp_stat_t                    stat,
    input  logic [stfs_pkg::IDX_W-1:0]            entry_index,
    input  logic signed [stfs_pkg::KEY_W-1:0]     key_value,
    input  logic                                  cfg_we,
    input  logic [stfs_pkg::CNT_W-1:0]            cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [stfs_pkg::IDX_W-1:0]            found_index,
    output logic                                  out_of_range
);
    import stfs_pkg::*;

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;

    logic [CNT_W-1:0]        entry_count_reg;
    logic [CNT_W-1:0]        cnt_eff;
    logic [CNT_W-1:0]        cnt_m1;

    logic signed [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0]        lower_reg;
    logic [CNT_W-1:0]        upper_reg;
    logic [IDX_W-1:0]        guess_reg;
    logic                    below_reg;
    logic [IDX_W-1:0]        res_idx_reg;
    logic                    res_oor_reg;

    logic                    out_valid_reg;
    logic [IDX_W-1:0]        found_index_reg;
    logic                    out_of_range_reg;

    logic                    key_lt_rd;
    logic                    rd_lt_key;
    logic                    exact;
    logic                    hit_oor;
    logic [IDX_W-1:0]        lo_c;
    logic [CNT_W-1:0]        up_c;
    logic [CNT_W-1:0]        span;
    logic                    narrow;
    logic [CNT_W:0]          guess_sum;
    logic [IDX_W-1:0]        guess_next;
    logic                    step;

    // The in-use count saturates into one to the table depth.
    always_comb
    begin
        priority if (entry_count_reg == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (entry_count_reg > CNT_W'(TABLE_DEPTH))
        begin
            cnt_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            cnt_eff = entry_count_reg;
        end
    end
    assign cnt_m1 = cnt_eff - CNT_W'(1);

    assign key_lt_rd = (key_reg < rd_data_reg);
    assign rd_lt_key = (rd_data_reg < key_reg);
    assign step      = ctl.chk_hi || ctl.srch;
    assign hit_oor   = below_reg || rd_lt_key;
    assign exact     = ctl.srch && (rd_data_reg == key_reg);

    // Bounds after this cycle's compare. The bound check cycle seeds the
    // full range; a search cycle narrows by the entry read at the guess.
    always_comb
    begin
        if (ctl.chk_hi)
        begin
            lo_c = '0;
            up_c = cnt_eff;
        end
        else if (key_lt_rd)
        begin
            lo_c = lower_reg;
            up_c = {1'b0, guess_reg};
        end
        else
        begin
            lo_c = guess_reg;
            up_c = upper_reg;
        end
    end

    assign span       = up_c - {1'b0, lo_c};
    assign narrow     = (span <= CNT_W'(1));
    assign guess_sum  = {2'b00, lo_c} + {1'b0, up_c};
    assign guess_next = guess_sum[IDX_W:1];

    assign stat.done     = (ctl.chk_hi && hit_oor) || (step && (exact || narrow));
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        priority if (ctl.start)
        begin
            rd_addr = '0;
        end
        else if (ctl.chk_lo)
        begin
            rd_addr = cnt_m1[IDX_W-1:0];
        end
        else
        begin
            rd_addr = guess_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[entry_index] <= key_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            key_reg <= key_value;
        end
        if (ctl.chk_lo)
        begin
            below_reg <= key_lt_rd;
        end
        if (step)
        begin
            lower_reg <= lo_c;
            upper_reg <= up_c;
            guess_reg <= guess_next;
        end
        if (stat.done)
        begin
            priority if (ctl.chk_hi && hit_oor)
            begin
                res_idx_reg <= '0;
                res_oor_reg <= 1'b1;
            end
            else if (exact)
            begin
                res_idx_reg <= guess_reg;
                res_oor_reg <= 1'b0;
            end
            else
            begin
                res_idx_reg <= lo_c;
                res_oor_reg <= 1'b0;
            end
        end
        if (ctl.emit && stat.out_free)
        begin
            found_index_reg  <= res_idx_reg;
            out_of_range_reg <= res_oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit && stat.out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found_index  = found_index_reg;
    assign out_of_range = out_of_range_reg;

`ifndef ASSERT_OFF
    a_oor_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (found_index == '0))
        else $error("out-of-range result carries a nonzero index");

    a_search_span: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.srch |-> (upper_reg - {1'b0, lower_reg}) >= CNT_W'(2))
        else $error("search step entered with a span below two");

    a_result_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (res_oor_reg || ({1'b0, res_idx_reg} < cnt_eff)))
        else $error("found index lies outside the in-use entries");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && stat.out_free) |=> out_valid)
        else $error("finished result was not presented on the output");
`endif

endmodule

FILE: src/sorted_table_floor_search.sv
// Lookup: after the lookup beat the controller passes through ST_CHK_LO, ST_CHK_HI,
// one ST_SRCH state per halving step and ST_EMIT, which loads the output register.
// Throughput: a write beat is taken every cycle while the controller is idle; a lookup
// stalls the input until ST_EMIT loads the output, one read per cycle on the single port.
// Reset clears the controller, the output valid and sets entry_count to one;
// the key table is not cleared and an entry must be written before it is read.
`timescale 1ns / 1ps

// Top level of the sorted-table floor search. It instantiates the controller
// (stfs_ctrl) and the datapath (stfs_dpath), both built on stfs_pkg.
module sorted_table_floor_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [stfs_pkg::IDX_W-1:0]        entry_index,
    input  logic signed [stfs_pkg::KEY_W-1:0] key_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stfs_pkg::IDX_W-1:0]        found_index,
    output logic                              out_of_range,
    input  logic                              cfg_we,
    input  logic [stfs_pkg::CNT_W-1:0]        cfg_wdata
);
    import stfs_pkg::*;

    // The controller walks a lookup through its phases. In ST_CHK_LO the
    // datapath holds entry zero, in ST_CHK_HI the last in-use entry;
    // together they decide whether the key is out of range. ST_CHK_HI
    // also issues the first guess read; each ST_SRCH state consumes the
    // entry read at the current guess, narrows the bounds and issues the
    // read for the next guess, so one halving step costs one state.
    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    // A write beat goes straight into the table from the idle state, so
    // writes stream at full rate and never produce a result beat.
    stfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The datapath owns the output register. A finished result waits in
    // the datapath's result register until the output register is free,
    // so a stalled output beat never loses or overwrites a result, and
    // new input beats are taken while an earlier result is still held.
    stfs_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .entry_index  (entry_index),
        .key_value    (key_value),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found_index  (found_index),
        .out_of_range (out_of_range)
    );

endmodule
